// File: sv/stpo_pkg.sv
// ----------------------------------------------------------------------------
// stpo_pkg
// Shared types, constants, the hold conversion and the per-slot update
// function of the sustained threshold power-off block.
// ----------------------------------------------------------------------------
package stpo_pkg;

   // field widths and fixed sizes
   localparam int FIELD_SLOTS        = 4;
   localparam int DEFAULT_SLOTS      = 4;
   localparam int VALUE_W            = 24;
   localparam int COUNT_W            = 20;
   localparam int ELAPSED_W          = 22;
   localparam int HOLD_W             = 16;
   localparam int CONTROL_W          = 8;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 64;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD_0  = 3'd0,
      CSR_THRESHOLD_1  = 3'd1,
      CSR_THRESHOLD_2  = 3'd2,
      CSR_THRESHOLD_3  = 3'd3,
      CSR_SLOT_CONTROL = 3'd4,
      CSR_HOLD_MINUTES = 3'd5
   } csr_index_type;

   // input item
   typedef struct packed {
      logic                      tick;
      logic                      arm_shutdown;
      logic                      cancel_shutdown;
      logic [COUNT_W-1:0]        shutdown_seconds;
      logic                      power_is_on;
      logic signed [VALUE_W-1:0] value_0;
      logic signed [VALUE_W-1:0] value_1;
      logic signed [VALUE_W-1:0] value_2;
      logic signed [VALUE_W-1:0] value_3;
   } req_type;

   // result item
   typedef struct packed {
      logic                   power_off;
      logic                   countdown_expired;
      logic [FIELD_SLOTS-1:0] slot_trips;
      logic                   countdown_active;
      logic [COUNT_W-1:0]     countdown_left;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [FIELD_SLOTS-1:0][VALUE_W-1:0] threshold;
      logic [CONTROL_W-1:0]                slot_control;
      logic [FIELD_SLOTS-1:0][HOLD_W-1:0]  hold_minutes;
   } cfg_type;

   // shutdown countdown state
   typedef struct packed {
      logic               on;
      logic [COUNT_W-1:0] count;
   } countdown_type;

   // one slot's new state and trip flag
   typedef struct packed {
      logic                 trip;
      logic                 timing;
      logic [ELAPSED_W-1:0] elapsed;
   } slot_type;

   // hold minutes to seconds: h*64 - h*4
   function automatic logic [ELAPSED_W-1:0] hold_seconds(input logic [HOLD_W-1:0] minutes);
      logic [ELAPSED_W-1:0] wide;
      wide = {{(ELAPSED_W-HOLD_W){1'b0}}, minutes};
      return (wide << 6) - (wide << 2);
   endfunction

   // one tick of one condition slot
   function automatic slot_type slot_step(
      input logic                 enabled,
      input logic                 run,
      input logic                 met,
      input logic [ELAPSED_W-1:0] hold,
      input logic                 timing,
      input logic [ELAPSED_W-1:0] elapsed
   );
      slot_type             res;
      logic [ELAPSED_W-1:0] inc;
      res.trip    = 1'b0;
      res.timing  = timing;
      res.elapsed = elapsed;
      inc         = (elapsed == {ELAPSED_W{1'b1}}) ? elapsed : elapsed + 1'b1;
      if (!enabled) begin
         res.timing  = 1'b0;
         res.elapsed = '0;
      end else if (run) begin
         if (!met) begin
            res.timing  = 1'b0;
            res.elapsed = '0;
         end else if (!timing) begin
            res.timing  = 1'b1;
            res.elapsed = '0;
         end else if (inc >= hold) begin
            res.trip    = 1'b1;
            res.timing  = 1'b0;
            res.elapsed = '0;
         end else begin
            res.elapsed = inc;
         end
      end
      return res;
   endfunction

endpackage

// File: sv/sustained_threshold_power_off_core.sv
// ----------------------------------------------------------------------------
// sustained_threshold_power_off_core
// Shutdown countdown and sustained-threshold watch over condition slots.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per second: tick, arm/cancel of the shutdown countdown,
//            countdown length, power state and one measured value per slot.
//   rsp_*  : one result per item: power-off request, countdown expiry, slot
//            trips, and the countdown state after the item.
//   csr_*  : write-only register port; write only while the block is idle.
//   A req transfer passes the compute stage and the output register before
//   rsp_valid. One item per cycle is sustained while results are taken: the
//   state row is read from the state memory on transfer and written back as
//   the stage advances, with the written row forwarded to the next item.
//   A stalled receiver holds the result in the output register; one more
//   item is taken into the compute stage and then req_ready drops until the
//   output register is freed.
//   Reset clears the valid and control registers and marks the state row
//   unwritten, which reads as all zero state (countdown off, slots idle). No clearing pass.
// ----------------------------------------------------------------------------
module sustained_threshold_power_off_core #(
   parameter int SLOTS = stpo_pkg::DEFAULT_SLOTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  stpo_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output stpo_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [stpo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stpo_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import stpo_pkg::*;

   localparam int ROW_W = 1 + COUNT_W + SLOTS + SLOTS * ELAPSED_W;

   cfg_type                            cfg_ff;
   logic                               s1_valid_ff;
   req_type                            s1_req_ff;
   logic [ROW_W-1:0]                   state_mem [1];
   logic                               mem_valid_ff;
   logic [ROW_W-1:0]                   rd_row_ff;
   logic                               rd_ok_ff;
   logic                               fwd_ff;
   logic [ROW_W-1:0]                   wb_row_ff;
   logic                               rsp_valid_ff;
   rsp_type                            rsp_data_ff;

   logic                               req_xfer;
   logic                               s1_adv;
   logic [ROW_W-1:0]                   cur_row;
   logic [ROW_W-1:0]                   nxt_row;
   countdown_type                      cd_cur;
   countdown_type                      cd_nxt;
   logic [SLOTS-1:0]                   timing_cur;
   logic [SLOTS-1:0]                   timing_nxt;
   logic [SLOTS-1:0][ELAPSED_W-1:0]    elapsed_cur;
   logic [SLOTS-1:0][ELAPSED_W-1:0]    elapsed_nxt;
   rsp_type                            rsp_nxt;

   // handshake control
   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign req_xfer  = req_valid & req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD_0:  cfg_ff.threshold[0] <= csr_wdata[VALUE_W-1:0];
            CSR_THRESHOLD_1:  cfg_ff.threshold[1] <= csr_wdata[VALUE_W-1:0];
            CSR_THRESHOLD_2:  cfg_ff.threshold[2] <= csr_wdata[VALUE_W-1:0];
            CSR_THRESHOLD_3:  cfg_ff.threshold[3] <= csr_wdata[VALUE_W-1:0];
            CSR_SLOT_CONTROL: cfg_ff.slot_control <= csr_wdata[CONTROL_W-1:0];
            CSR_HOLD_MINUTES: cfg_ff.hold_minutes <= csr_wdata;
            default: ;
         endcase
      end
   end

   // compute stage valid and item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff <= req_data;
      end
   end

   // state memory: read on transfer, write back when the stage advances
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         state_mem[0] <= nxt_row;
      end
      if (req_xfer) begin
         rd_row_ff <= state_mem[0];
      end
      if (s1_adv) begin
         wb_row_ff <= nxt_row;
      end
   end

   // row-written flag, read qualifier and forward select
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         if (s1_adv) begin
            mem_valid_ff <= 1'b1;
         end
         if (req_xfer) begin
            rd_ok_ff <= mem_valid_ff;
            fwd_ff   <= s1_adv;
         end
      end
   end

   // current row: forwarded write, stored row, or reset state
   always_comb begin
      if (fwd_ff) begin
         cur_row = wb_row_ff;
      end else if (rd_ok_ff) begin
         cur_row = rd_row_ff;
      end else begin
         cur_row = '0;
      end
   end

   assign cd_cur.on    = cur_row[0];
   assign cd_cur.count = cur_row[COUNT_W:1];
   assign timing_cur   = cur_row[COUNT_W+1 +: SLOTS];
   assign elapsed_cur  = cur_row[ROW_W-1 -: SLOTS*ELAPSED_W];
   assign nxt_row      = {elapsed_nxt, timing_nxt, cd_nxt.count, cd_nxt.on};

   stpo_update #(
      .SLOTS(SLOTS)
   ) u_update (
      .cfg         (cfg_ff),
      .req         (s1_req_ff),
      .cd_cur      (cd_cur),
      .timing_cur  (timing_cur),
      .elapsed_cur (elapsed_cur),
      .cd_nxt      (cd_nxt),
      .timing_nxt  (timing_nxt),
      .elapsed_nxt (elapsed_nxt),
      .rsp         (rsp_nxt)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_nxt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an expired countdown leaves it off and at zero
   a_expired_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.countdown_expired |->
         !rsp_data.countdown_active && (rsp_data.countdown_left == '0))
      else $error("expired countdown still active");

   // power-off request matches its causes
   a_power_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.power_off ==
         (rsp_data.countdown_expired || (rsp_data.slot_trips != '0)))
      else $error("power_off does not match expiry and trips");

   // a write-back racing a new read is always forwarded
   a_forward: assert property (@(posedge clock) disable iff (reset)
      req_xfer && s1_adv |=> fwd_ff && s1_valid_ff)
      else $error("write-back not forwarded to next item");
`endif

endmodule

// File: sv/stpo_update.sv
// ----------------------------------------------------------------------------
// stpo_update
// Next-state logic for one item: countdown commands and tick, then every
// condition slot, and the result item.
// ----------------------------------------------------------------------------
module stpo_update #(
   parameter int SLOTS = stpo_pkg::DEFAULT_SLOTS
) (
   input  stpo_pkg::cfg_type                                 cfg,
   input  stpo_pkg::req_type                                 req,
   input  stpo_pkg::countdown_type                           cd_cur,
   input  logic [SLOTS-1:0]                                  timing_cur,
   input  logic [SLOTS-1:0][stpo_pkg::ELAPSED_W-1:0]         elapsed_cur,
   output stpo_pkg::countdown_type                           cd_nxt,
   output logic [SLOTS-1:0]                                  timing_nxt,
   output logic [SLOTS-1:0][stpo_pkg::ELAPSED_W-1:0]         elapsed_nxt,
   output stpo_pkg::rsp_type                                 rsp
);
   import stpo_pkg::*;

   logic                         run;
   countdown_type                cd_cmd;
   logic                         expired;
   logic [COUNT_W-1:0]           cd_dec;
   logic [FIELD_SLOTS-1:0][VALUE_W-1:0] values;
   slot_type                     slot_res [SLOTS];
   logic [SLOTS-1:0]             trips;
   logic [FIELD_SLOTS-1:0]       trips_out;

   assign run    = req.tick & req.power_is_on;
   assign values = {req.value_3, req.value_2, req.value_1, req.value_0};

   // arm wins over cancel, then the tick
   always_comb begin
      cd_cmd = cd_cur;
      if (req.arm_shutdown) begin
         cd_cmd.on    = 1'b1;
         cd_cmd.count = req.shutdown_seconds;
      end else if (req.cancel_shutdown) begin
         cd_cmd.on    = 1'b0;
         cd_cmd.count = '0;
      end
   end

   assign cd_dec = cd_cmd.count - 1'b1;

   always_comb begin
      cd_nxt  = cd_cmd;
      expired = 1'b0;
      if (run && cd_cmd.on && (cd_cmd.count != '0)) begin
         cd_nxt.count = cd_dec;
         if (cd_dec == '0) begin
            expired   = 1'b1;
            cd_nxt.on = 1'b0;
         end
      end
   end

   // condition slots, each independent
   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      if (i < FIELD_SLOTS) begin : g_field
         logic signed [VALUE_W-1:0] val;
         logic signed [VALUE_W-1:0] thr;
         logic                      met;
         assign val = $signed(values[i]);
         assign thr = $signed(cfg.threshold[i]);
         assign met = cfg.slot_control[FIELD_SLOTS+i] ? (val > thr) : (val < thr);
         assign slot_res[i] = slot_step(cfg.slot_control[i], run, met,
                                        hold_seconds(cfg.hold_minutes[i]),
                                        timing_cur[i], elapsed_cur[i]);
      end else begin : g_spare
         // no value or threshold: always disabled
         assign slot_res[i] = slot_step(1'b0, run, 1'b0, '0,
                                        timing_cur[i], elapsed_cur[i]);
      end
      assign timing_nxt[i]  = slot_res[i].timing;
      assign elapsed_nxt[i] = slot_res[i].elapsed;
      assign trips[i]       = slot_res[i].trip;
   end

   // trip flags of the field slots
   always_comb begin
      trips_out = '0;
      for (int i = 0; i < FIELD_SLOTS; i++) begin
         if (i < SLOTS) begin
            trips_out[i] = trips[i];
         end
      end
   end

   // result item
   assign rsp.power_off         = expired | (|trips);
   assign rsp.countdown_expired = expired;
   assign rsp.slot_trips        = trips_out;
   assign rsp.countdown_active  = cd_nxt.on;
   assign rsp.countdown_left    = cd_nxt.count;

endmodule

// File: sim/sustained_threshold_power_off_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sustained_threshold_power_off_core_tb
// Self-checking bench for the shutdown countdown and the sustained-threshold
// slot watch. A directed script covers countdown arm/cancel corners,
// threshold extremes, zero hold and slot disable. Random phases with
// different register settings then follow. Every result is checked against
// a fixed script expectation or a cycle-free model of the countdown and the
// slot timers. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module sustained_threshold_power_off_core_tb;
   import stpo_pkg::*;

   localparam int REQ_W = $bits(req_type);

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block ports
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sustained_threshold_power_off_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model copy of the registers
   logic signed [VALUE_W-1:0] cfg_threshold [FIELD_SLOTS];
   logic [CONTROL_W-1:0]      cfg_control = '0;
   logic [CSR_DATA_W-1:0]     cfg_hold    = '0;

   // model copy of the countdown and slot timers
   logic                      cd_armed   = 1'b0;
   logic [COUNT_W-1:0]        cd_seconds = '0;
   logic                      slot_running [FIELD_SLOTS];
   logic [ELAPSED_W-1:0]      slot_seconds [FIELD_SLOTS];

   // outcomes still to arrive, oldest first
   rsp_type outcome_queue [$];
   int      failures = 0;

   // chance in percent that a slot's condition breaks on an item
   int      slot_break [FIELD_SLOTS];

   // stretches with no idling on either side
   logic    quiet      = 1'b0;
   int      quiet_span = 0;
   int      hold_off   = 0;

   initial begin
      for (int i = 0; i < FIELD_SLOTS; i++) begin
         cfg_threshold[i] = '0;
         slot_running[i]  = 1'b0;
         slot_seconds[i]  = '0;
         slot_break[i]    = 0;
      end
   end

   // one row of the directed script: a register write or an item
   typedef struct {
      bit            is_write;
      csr_index_type reg_index;
      logic [63:0]   reg_data;
      req_type       item;
      bit            fixed;
      rsp_type       want;
   } script_row_type;

   script_row_type script [$];

   // idle length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one item through the countdown and slot timers
   task automatic advance_watch(input req_type it, output rsp_type res);
      logic                      run;
      logic                      expired;
      logic [FIELD_SLOTS-1:0]    trips;
      logic                      met;
      int unsigned               hold_s;
      logic signed [VALUE_W-1:0] v [FIELD_SLOTS];
      run     = it.tick && it.power_is_on;
      expired = 1'b0;
      trips   = '0;
      v[0]    = it.value_0;
      v[1]    = it.value_1;
      v[2]    = it.value_2;
      v[3]    = it.value_3;
      // commands first, arm wins over cancel
      if (it.arm_shutdown) begin
         cd_armed   = 1'b1;
         cd_seconds = it.shutdown_seconds;
      end else if (it.cancel_shutdown) begin
         cd_armed   = 1'b0;
         cd_seconds = '0;
      end
      // countdown, a zero count never fires
      if (run && cd_armed && cd_seconds != 0) begin
         cd_seconds = cd_seconds - 1'b1;
         if (cd_seconds == 0) begin
            expired  = 1'b1;
            cd_armed = 1'b0;
         end
      end
      // slot timers
      for (int i = 0; i < FIELD_SLOTS; i++) begin
         if (!cfg_control[i]) begin
            slot_running[i] = 1'b0;
            slot_seconds[i] = '0;
         end else if (run) begin
            met    = cfg_control[4+i] ? (v[i] > cfg_threshold[i])
                                      : (v[i] < cfg_threshold[i]);
            hold_s = cfg_hold[16*i +: 16] * 60;
            if (!met) begin
               slot_running[i] = 1'b0;
               slot_seconds[i] = '0;
            end else if (!slot_running[i]) begin
               slot_running[i] = 1'b1;
               slot_seconds[i] = '0;
            end else begin
               if (slot_seconds[i] != {ELAPSED_W{1'b1}})
                  slot_seconds[i] = slot_seconds[i] + 1'b1;
               if (slot_seconds[i] >= hold_s) begin
                  trips[i]        = 1'b1;
                  slot_running[i] = 1'b0;
                  slot_seconds[i] = '0;
               end
            end
         end
      end
      res.power_off         = expired || (trips != 0);
      res.countdown_expired = expired;
      res.slot_trips        = trips;
      res.countdown_active  = cd_armed;
      res.countdown_left    = cd_seconds;
   endtask

   // compare one received result with the oldest outcome
   task automatic check_outcome(input rsp_type got);
      rsp_type want;
      if (outcome_queue.size() == 0) begin
         $error("result with nothing outstanding: %h", got);
         failures++;
      end else begin
         want = outcome_queue.pop_front();
         if (got.power_off !== want.power_off) begin
            $error("power_off expected %0d got %0d", want.power_off, got.power_off);
            failures++;
         end
         if (got.countdown_expired !== want.countdown_expired) begin
            $error("countdown_expired expected %0d got %0d",
                   want.countdown_expired, got.countdown_expired);
            failures++;
         end
         if (got.slot_trips !== want.slot_trips) begin
            $error("slot_trips expected %b got %b", want.slot_trips, got.slot_trips);
            failures++;
         end
         if (got.countdown_active !== want.countdown_active) begin
            $error("countdown_active expected %0d got %0d",
                   want.countdown_active, got.countdown_active);
            failures++;
         end
         if (got.countdown_left !== want.countdown_left) begin
            $error("countdown_left expected %0d got %0d",
                   want.countdown_left, got.countdown_left);
            failures++;
         end
      end
   endtask

   // wait until every outcome is in and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write while idle, model copy follows
   task automatic write_reg(input csr_index_type idx, input logic [63:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_THRESHOLD_0:  cfg_threshold[0] = data[VALUE_W-1:0];
         CSR_THRESHOLD_1:  cfg_threshold[1] = data[VALUE_W-1:0];
         CSR_THRESHOLD_2:  cfg_threshold[2] = data[VALUE_W-1:0];
         CSR_THRESHOLD_3:  cfg_threshold[3] = data[VALUE_W-1:0];
         CSR_SLOT_CONTROL: cfg_control      = data[CONTROL_W-1:0];
         CSR_HOLD_MINUTES: cfg_hold         = data;
         default: ;
      endcase
   endtask

   // one input transfer, outcome queued at acceptance
   task automatic send_item(input req_type item, input bit fixed, input rsp_type want);
      int      gap;
      rsp_type calc;
      csr_we <= 1'b0;
      gap = quiet ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_watch(item, calc);
      outcome_queue = {outcome_queue, (fixed ? want : calc)};
   endtask

   // script helpers
   function automatic req_type make_item(bit tk, bit arm, bit cancel, int secs, bit pwr,
                                         int v0, int v1, int v2, int v3);
      req_type it;
      it.tick             = tk;
      it.arm_shutdown     = arm;
      it.cancel_shutdown  = cancel;
      it.shutdown_seconds = COUNT_W'(secs);
      it.power_is_on      = pwr;
      it.value_0          = VALUE_W'(v0);
      it.value_1          = VALUE_W'(v1);
      it.value_2          = VALUE_W'(v2);
      it.value_3          = VALUE_W'(v3);
      return it;
   endfunction

   function automatic rsp_type countdown_only(bit po, bit ex, bit act, int left);
      return rsp_type'{po, ex, 4'h0, act, COUNT_W'(left)};
   endfunction

   function automatic logic [63:0] wide24(int v);
      logic [VALUE_W-1:0] b;
      b = VALUE_W'(v);
      return {{(64-VALUE_W){b[VALUE_W-1]}}, b};
   endfunction

   task automatic add_item(input req_type it);
      script_row_type row;
      row          = '{1'b0, CSR_THRESHOLD_0, '0, '0, 1'b0, '0};
      row.item     = it;
      script       = {script, row};
   endtask

   task automatic add_fixed(input req_type it, input rsp_type want);
      script_row_type row;
      row          = '{1'b0, CSR_THRESHOLD_0, '0, '0, 1'b0, '0};
      row.item     = it;
      row.fixed    = 1'b1;
      row.want     = want;
      script       = {script, row};
   endtask

   task automatic add_write(input csr_index_type idx, input logic [63:0] data);
      script_row_type row;
      row           = '{1'b0, CSR_THRESHOLD_0, '0, '0, 1'b0, '0};
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_data  = data;
      script        = {script, row};
   endtask

   // random item, mostly values that hold each slot's condition
   function automatic req_type random_item();
      req_type                   it;
      logic [REQ_W-1:0]          raw;
      int                        t, x, off, r;
      logic signed [VALUE_W-1:0] v [FIELD_SLOTS];
      if ($urandom_range(0, 99) < 3) begin
         raw = REQ_W'({$urandom, $urandom, $urandom, $urandom});
         it  = raw;
         return it;
      end
      it.tick            = $urandom_range(0, 99) < 92;
      it.power_is_on     = $urandom_range(0, 99) < 90;
      it.arm_shutdown    = $urandom_range(0, 99) < 3;
      it.cancel_shutdown = $urandom_range(0, 99) < 3;
      r = $urandom_range(0, 99);
      if (r < 70)      it.shutdown_seconds = COUNT_W'($urandom_range(0, 30));
      else if (r < 90) it.shutdown_seconds = COUNT_W'($urandom_range(31, 500));
      else             it.shutdown_seconds = COUNT_W'($urandom);
      for (int i = 0; i < FIELD_SLOTS; i++) begin
         r = $urandom_range(0, 99);
         t = int'(cfg_threshold[i]);
         if (r >= 97) begin
            v[i] = VALUE_W'($urandom);
         end else if (r < slot_break[i]) begin
            v[i] = $urandom_range(0, 1) ? cfg_threshold[i] : VALUE_W'($urandom);
         end else begin
            off = $urandom_range(1, 400);
            x   = cfg_control[4+i] ? t + off : t - off;
            if (x > 8388607)  x = 8388607;
            if (x < -8388608) x = -8388608;
            v[i] = VALUE_W'(x);
         end
      end
      it.value_0 = v[0];
      it.value_1 = v[1];
      it.value_2 = v[2];
      it.value_3 = v[3];
      return it;
   endfunction

   // register settings of one random phase
   task automatic configure_phase(input int p);
      logic [63:0] thr [FIELD_SLOTS];
      logic [7:0]  ctl;
      logic [63:0] hold;
      int          picks [5];
      picks = '{0, 1, 2, 10, 40};
      case (p)
         0: begin
            for (int i = 0; i < FIELD_SLOTS; i++) thr[i] = wide24($urandom);
            ctl  = 8'hFF;
            hold = '1;
         end
         1: begin
            for (int i = 0; i < FIELD_SLOTS; i++) thr[i] = wide24($urandom);
            ctl  = 8'h00;
            hold = {$urandom, $urandom};
         end
         2: begin
            for (int i = 0; i < FIELD_SLOTS; i++) thr[i] = wide24(-8388608);
            ctl  = 8'hFF;
            hold = '0;
         end
         3: begin
            for (int i = 0; i < FIELD_SLOTS; i++) thr[i] = wide24(8388607);
            ctl  = 8'h0F;
            hold = {16'd2, 16'd1, 16'd0, 16'd1};
         end
         default: begin
            for (int i = 0; i < FIELD_SLOTS; i++)
               thr[i] = wide24(int'($urandom_range(0, 10000)) - 5000);
            ctl  = 8'($urandom_range(0, 255));
            hold = {16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                    16'($urandom_range(0, 2)), 16'($urandom_range(0, 2))};
         end
      endcase
      for (int i = 0; i < FIELD_SLOTS; i++) begin
         write_reg(csr_index_type'(CSR_THRESHOLD_0 + i), thr[i]);
         slot_break[i] = picks[$urandom_range(0, 4)];
      end
      write_reg(CSR_SLOT_CONTROL, {56'h0, ctl});
      write_reg(CSR_HOLD_MINUTES, hold);
   endtask

   // result side: random stalls, check every transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_outcome(rsp_data);
         if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20) hold_off <= gap_len();
         end
      end
   end

   // switch between idling and no-idling stretches
   always @(posedge clock) begin
      if (quiet_span == 0) begin
         quiet      <= $urandom_range(0, 99) < 25;
         quiet_span <= $urandom_range(50, 400);
      end else begin
         quiet_span <= quiet_span - 1;
      end
   end

   // stimulus
   initial begin
      // countdown corners, slots disabled after reset
      add_fixed(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0), countdown_only(0, 0, 0, 0));
      add_fixed(make_item(1, 1, 0, 0, 1, 0, 0, 0, 0), countdown_only(0, 0, 1, 0));
      add_fixed(make_item(1, 0, 0, 0, 1, 0, 0, 0, 0), countdown_only(0, 0, 1, 0));
      add_fixed(make_item(1, 1, 0, 1, 1, 0, 0, 0, 0), countdown_only(1, 1, 0, 0));
      add_fixed(make_item(1, 1, 0, 1048575, 1, 0, 0, 0, 0),
                countdown_only(0, 0, 1, 1048574));
      add_fixed(make_item(1, 0, 0, 0, 0, 0, 0, 0, 0), countdown_only(0, 0, 1, 1048574));
      add_fixed(make_item(0, 0, 0, 0, 1, 0, 0, 0, 0), countdown_only(0, 0, 1, 1048574));
      add_fixed(make_item(1, 1, 1, 3, 1, 0, 0, 0, 0), countdown_only(0, 0, 1, 2));
      add_fixed(make_item(1, 0, 1, 5, 1, 0, 0, 0, 0), countdown_only(0, 0, 0, 0));
      add_fixed(make_item(1, 0, 0, 0, 1, 0, 0, 0, 0), countdown_only(0, 0, 0, 0));
      // threshold extremes, zero hold: slot 0 less than max, slot 1 greater
      // than min, slot 2 greater than zero, slot 3 less than 256
      add_write(CSR_THRESHOLD_0, wide24(8388607));
      add_write(CSR_THRESHOLD_1, wide24(-8388608));
      add_write(CSR_THRESHOLD_2, wide24(0));
      add_write(CSR_THRESHOLD_3, wide24(256));
      add_write(CSR_SLOT_CONTROL, 64'h6F);
      add_write(CSR_HOLD_MINUTES, 64'h0);
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      // values equal to the thresholds break the conditions
      add_item(make_item(1, 0, 0, 0, 1, 8388607, -8388608, 0, 256));
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      // no tick, and tick without power: timers hold
      add_item(make_item(0, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      add_item(make_item(1, 0, 0, 0, 0, -8388608, 8388607, 1, 255));
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      // disabled slots clear their timing even without a tick
      add_write(CSR_SLOT_CONTROL, 64'h60);
      add_item(make_item(0, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      add_write(CSR_SLOT_CONTROL, 64'h6F);
      add_item(make_item(1, 0, 0, 0, 1, -8388608, 8388607, 1, 255));
      // countdown expiry together with slot trips
      add_item(make_item(1, 1, 0, 1, 1, -8388608, 8388607, 1, 255));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_write) write_reg(script[k].reg_index, script[k].reg_data);
         else send_item(script[k].item, script[k].fixed, script[k].want);
      end

      // random phases
      for (int p = 0; p < 7; p++) begin
         configure_phase(p);
         for (int n = 0; n < 250; n++) send_item(random_item(), 1'b0, '0);
      end

      settle();
      repeat (5) @(posedge clock);
      if (failures == 0 && outcome_queue.size() == 0)
         $display("sustained_threshold_power_off_core_tb: done, clean");
      else
         $display("sustained_threshold_power_off_core_tb: done, errors");
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("sustained_threshold_power_off_core_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
sv/stpo_pkg.sv
sv/stpo_update.sv
sv/sustained_threshold_power_off_core.sv
sim/sustained_threshold_power_off_core_tb.sv
